// ===== rtl/core/deq_pkg.sv =====
// Package for the double-ended queue: command and status codes, controller
// states, the controller-to-datapath command struct and default sizes.
// No dependencies.
`default_nettype none

package deq_pkg;

  // Default sizes; external words are always this wide
  localparam int DEPTH_DEFAULT     = 16;
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int IO_BITS           = 32;

  // Request commands
  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } deq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } deq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;   // apply the accepted request to the ring
    logic load;   // load the result register
  } deq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// Controller for the double-ended queue: sequences request acceptance,
// ring read and result load, and owns the output valid flag.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output deq_pkg::deq_ctl_t      ctl
);

  deq_pkg::deq_state_t state, state_next;
  logic                out_valid_next;

  // State and valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    ctl            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.exec   = 1'b1;
          state_next = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        state_next = deq_pkg::ST_LOAD;
      end
      deq_pkg::ST_LOAD: begin
        // wait until the previous result has been taken
        if (!out_valid || !out_stall) begin
          ctl.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/deq_dp.sv =====
// Datapath for the double-ended queue: ring memory, head pointer, count,
// two-port registered read and the result register.
// Depends on deq_pkg.
`default_nettype none

module deq_dp #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT,
  localparam int PTR_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire deq_pkg::deq_ctl_t                 ctl,
  input  wire logic [1:0]                        command,
  input  wire logic signed [deq_pkg::IO_BITS-1:0] value,
  output logic signed [deq_pkg::IO_BITS-1:0]     front_word,
  output logic signed [deq_pkg::IO_BITS-1:0]     back_word,
  output logic [CNT_W-1:0]                       occupancy,
  output logic                                   is_vacant,
  output logic [1:0]                             status
);

  localparam int SUM_W = CNT_W + 1;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [PTR_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  deq_pkg::deq_status_t stat, stat_next;
  logic [WORD_BITS-1:0] rd_front, rd_back;

  deq_pkg::deq_op_t     op;
  logic [WORD_BITS-1:0] in_word;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     tail_addr, head_dec, head_inc, back_addr;
  logic [SUM_W-1:0]     tail_sum, back_sum;
  logic                 full, empty;

  assign op      = deq_pkg::deq_op_t'(command);
  assign in_word = WORD_BITS'($unsigned(value));
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  // Ring arithmetic: sums stay below twice the depth, one subtract wraps
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
  assign head_dec  = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
  assign head_inc  = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);

  // Request decode
  always_comb begin
    head_next  = head;
    count_next = count;
    stat_next  = deq_pkg::STAT_DONE;
    wr_en      = 1'b0;
    wr_addr    = tail_addr;
    unique case (op)
      deq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          stat_next = deq_pkg::STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          stat_next = deq_pkg::STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          stat_next = deq_pkg::STAT_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          stat_next = deq_pkg::STAT_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        stat_next = deq_pkg::STAT_DONE;
      end
    endcase
  end

  // Pointer, count and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      stat <= stat_next;
    end
  end

  // Back slot address of the current state; head when empty (unused)
  assign back_sum  = SUM_W'(head) + SUM_W'(count) - SUM_W'(1);
  assign back_addr = empty ? head
                   : (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(back_sum);

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_front <= mem[head];
    rd_back  <= mem[back_addr];
  end

  // Result register; words read as zero when empty
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      front_word <= empty ? '0 : $signed(deq_pkg::IO_BITS'(rd_front));
      back_word  <= empty ? '0 : $signed(deq_pkg::IO_BITS'(rd_back));
      occupancy  <= count;
      is_vacant  <= empty;
      status     <= stat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue_top.sv =====
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_dp.
//
// Bounded double-ended queue in a DEPTH-slot ring buffer. Each request
// carries a command (push back, push front, pop back, pop front) and a
// value used only by pushes; each request yields exactly one result with
// the front and back words, occupancy, an empty flag and a status (done,
// pop on empty ignored, push on full ignored). Front and back read as zero
// when the queue is empty. A request goes in order through these steps:
// the head pointer and count are updated and the slot written, the ring
// memory gets its two-port registered read, and the result register is
// loaded. A new request is accepted only once the previous result is
// loaded, and is accepted while an earlier result still waits at the
// output; the result load stalls only if that earlier result is not taken.
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         command,
  input  wire logic signed [deq_pkg::IO_BITS-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [deq_pkg::IO_BITS-1:0]      front_word,
  output logic signed [deq_pkg::IO_BITS-1:0]      back_word,
  output logic [CNT_W-1:0]                        occupancy,
  output logic                                    is_vacant,
  output logic [1:0]                              status
);

  deq_pkg::deq_ctl_t ctl;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  deq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .command    (command),
    .value      (value),
    .front_word (front_word),
    .back_word  (back_word),
    .occupancy  (occupancy),
    .is_vacant  (is_vacant),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/deq_checker.sv =====
// Port-level checker for the double-ended queue and its bind to the top.
// Depends on deq_pkg and double_ended_queue_top.
`default_nettype none

module deq_checker #(
  parameter int DEPTH    = deq_pkg::DEPTH_DEFAULT,
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [deq_pkg::IO_BITS-1:0] front_word,
  input wire logic signed [deq_pkg::IO_BITS-1:0] back_word,
  input wire logic [CNT_W-1:0]                   occupancy,
  input wire logic                               is_vacant,
  input wire logic [1:0]                         status
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_word) && $stable(back_word)
      && $stable(occupancy) && $stable(status))
    else $error("stalled result changed");

  // One request in flight: the cycle after an accept the input is stalled
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // Empty queue reports zero words and zero occupancy
  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_vacant |-> front_word == '0 && back_word == '0 && occupancy == '0)
    else $error("empty result carries data");

  // Status agrees with occupancy
  a_status_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(DEPTH)
      && (status != deq_pkg::STAT_FULL || occupancy == CNT_W'(DEPTH))
      && (status != deq_pkg::STAT_EMPTY || is_vacant))
    else $error("status inconsistent with occupancy");

endmodule

bind double_ended_queue_top deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .front_word (front_word),
  .back_word  (back_word),
  .occupancy  (occupancy),
  .is_vacant  (is_vacant),
  .status     (status)
);

`default_nettype wire
